// ----- hw/rtl/kaa_pkg.sv -----
package kaa_pkg;

  // fixed field widths
  localparam int COORD_BITS   = 16;
  localparam int SLOT_BITS    = 3;
  localparam int NC_BITS      = 4;
  localparam int DIST_BITS    = 34;
  localparam int OUT_SUM_BITS = 40;
  localparam int COUNT_BITS   = 24;

  // |dx|^2 + |dy|^2 needs one bit over a square
  localparam int DIST_W = 2 * COORD_BITS + 1;

  // parameter defaults
  localparam int MAX_CENTERS_DEF = 8;
  localparam int SUM_BITS_DEF    = 40;

  localparam logic [NC_BITS-1:0] NC_RESET = NC_BITS'(2);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // one decoded word in the command queue
  typedef struct packed {
    op_t                           op;
    logic                          in_range;
    logic [SLOT_BITS-1:0]          slot;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
  } cmd_t;

endpackage

// ----- hw/rtl/kaa_front.sv -----
module kaa_front import kaa_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    operation,
  input  logic [SLOT_BITS-1:0]          center_slot,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  output logic                          busy,
  input  logic                          pop,
  output logic                          cmd_valid,
  output cmd_t                          cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       dec;

  // classify the incoming word
  always_comb begin
    dec.op       = op_t'(operation);
    dec.in_range = (int'(center_slot) < MAX_CENTERS);
    dec.slot     = center_slot;
    dec.x        = coord_x;
    dec.y        = coord_y;
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/kaa_back.sv -----
module kaa_back import kaa_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  cmd_t                          cmd,
  output logic                          pop,
  input  logic [NC_BITS-1:0]            num_centers,
  output logic                          done,
  output logic [SLOT_BITS-1:0]          cluster_index,
  output logic [DIST_BITS-1:0]          best_distance,
  output logic signed [OUT_SUM_BITS-1:0] sum_x,
  output logic signed [OUT_SUM_BITS-1:0] sum_y,
  output logic [COUNT_BITS-1:0]         member_count
);

  localparam int IDX_W = $clog2(MAX_CENTERS);
  localparam int CW    = $clog2(MAX_CENTERS + 1);
  localparam int LW    = (CW > NC_BITS) ? CW : NC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_CMP,
    S_ACC,
    S_RES
  } state_t;

  state_t                   state;
  cmd_t                     cmd_q;
  logic [IDX_W-1:0]         iter;
  logic [IDX_W-1:0]         best_idx;
  logic [DIST_W-1:0]        best_d;
  logic [2*COORD_BITS-1:0]  sqx;
  logic [2*COORD_BITS-1:0]  sqy;
  logic [IDX_W-1:0]         acc_addr;
  logic [MAX_CENTERS-1:0]   valid;

  // center memories
  logic signed [COORD_BITS-1:0] cx_mem [MAX_CENTERS];
  logic signed [COORD_BITS-1:0] cy_mem [MAX_CENTERS];
  logic signed [COORD_BITS-1:0] cx_q;
  logic signed [COORD_BITS-1:0] cy_q;

  // accumulator memories, qualified by valid
  logic signed [SUM_BITS-1:0] ax_mem [MAX_CENTERS];
  logic signed [SUM_BITS-1:0] ay_mem [MAX_CENTERS];
  logic [COUNT_BITS-1:0]      ac_mem [MAX_CENTERS];
  logic signed [SUM_BITS-1:0] ax_q;
  logic signed [SUM_BITS-1:0] ay_q;
  logic [COUNT_BITS-1:0]      ac_q;
  logic                       av_q;

  logic [IDX_W-1:0]           slot_idx;
  logic                       ctr_we;
  logic                       acc_we;
  logic [LW-1:0]              nc_w;
  logic [LW-1:0]              n_eff;
  logic [LW-1:0]              iter_next;
  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic [COORD_BITS-1:0]      mag_x;
  logic [COORD_BITS-1:0]      mag_y;
  logic [DIST_W-1:0]          d;
  logic                       take_new;
  logic [IDX_W-1:0]           win_idx;
  logic signed [SUM_BITS-1:0] eff_x;
  logic signed [SUM_BITS-1:0] eff_y;
  logic [COUNT_BITS-1:0]      eff_c;
  logic signed [SUM_BITS-1:0] new_x;
  logic signed [SUM_BITS-1:0] new_y;
  logic [COUNT_BITS-1:0]      new_c;
  logic                       show;

  assign pop      = (state == S_IDLE) && cmd_valid;
  assign slot_idx = IDX_W'(cmd.slot);
  assign ctr_we   = pop && (cmd.op == OP_LOAD) && cmd.in_range;
  assign acc_we   = (state == S_RES) && (cmd_q.op == OP_ASSIGN);

  // clamp center count to 1 .. MAX_CENTERS
  always_comb begin
    nc_w = LW'(num_centers);
    if (nc_w == '0) begin
      n_eff = LW'(1);
    end else if (nc_w > LW'(MAX_CENTERS)) begin
      n_eff = LW'(MAX_CENTERS);
    end else begin
      n_eff = nc_w;
    end
    iter_next = LW'(iter) + LW'(1);
  end

  // distance datapath
  always_comb begin
    diff_x   = (COORD_BITS+1)'(cmd_q.x) - (COORD_BITS+1)'(cx_q);
    diff_y   = (COORD_BITS+1)'(cmd_q.y) - (COORD_BITS+1)'(cy_q);
    mag_x    = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    mag_y    = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    d        = DIST_W'(sqx) + DIST_W'(sqy);
    take_new = (iter == '0) || (d < best_d);
    win_idx  = take_new ? iter : best_idx;
  end

  // accumulator update
  always_comb begin
    eff_x = av_q ? ax_q : '0;
    eff_y = av_q ? ay_q : '0;
    eff_c = av_q ? ac_q : '0;
    new_x = eff_x + SUM_BITS'(cmd_q.x);
    new_y = eff_y + SUM_BITS'(cmd_q.y);
    new_c = (eff_c == '1) ? eff_c : eff_c + COUNT_BITS'(1);
    show  = cmd_q.in_range;
  end

  always_ff @(posedge clk) begin
    if (ctr_we) begin
      cx_mem[slot_idx] <= cmd.x;
      cy_mem[slot_idx] <= cmd.y;
    end
    cx_q <= cx_mem[iter];
    cy_q <= cy_mem[iter];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      ax_mem[acc_addr] <= new_x;
      ay_mem[acc_addr] <= new_y;
      ac_mem[acc_addr] <= new_c;
    end
    ax_q <= ax_mem[acc_addr];
    ay_q <= ay_mem[acc_addr];
    ac_q <= ac_mem[acc_addr];
    av_q <= valid[acc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            case (cmd.op)
              OP_LOAD, OP_READ: begin
                acc_addr <= slot_idx;
                state    <= S_ACC;
              end
              OP_ASSIGN: begin
                iter  <= '0;
                state <= S_RD;
              end
              OP_CLEAR: begin
                valid         <= '0;
                done          <= 1'b1;
                cluster_index <= cmd.slot;
                best_distance <= '0;
                sum_x         <= '0;
                sum_y         <= '0;
                member_count  <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          sqx   <= (2*COORD_BITS)'(mag_x) * (2*COORD_BITS)'(mag_x);
          sqy   <= (2*COORD_BITS)'(mag_y) * (2*COORD_BITS)'(mag_y);
          state <= S_CMP;
        end
        S_CMP: begin
          if (take_new) begin
            best_d   <= d;
            best_idx <= iter;
          end
          if (iter_next < n_eff) begin
            iter  <= IDX_W'(iter_next);
            state <= S_RD;
          end else begin
            acc_addr <= win_idx;
            state    <= S_ACC;
          end
        end
        S_ACC: state <= S_RES;
        S_RES: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (cmd_q.op == OP_ASSIGN) begin
            valid[acc_addr] <= 1'b1;
            cluster_index   <= SLOT_BITS'(acc_addr);
            best_distance   <= DIST_BITS'(best_d);
            sum_x           <= OUT_SUM_BITS'(new_x);
            sum_y           <= OUT_SUM_BITS'(new_y);
            member_count    <= new_c;
          end else begin
            cluster_index <= cmd_q.slot;
            best_distance <= '0;
            sum_x         <= show ? OUT_SUM_BITS'(eff_x) : '0;
            sum_y         <= show ? OUT_SUM_BITS'(eff_y) : '0;
            member_count  <= show ? eff_c : '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_res_done: assert property (@(posedge clk) disable iff (rst) (state == S_RES) |=> done)
    else $error("result strobe missing after accumulate");
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (LW'(iter) < n_eff))
    else $error("center scan ran past center count");
  a_dist_assign_only: assert property (@(posedge clk) disable iff (rst)
    done |-> (cmd_q.op == OP_ASSIGN || best_distance == '0))
    else $error("nonzero distance on non-assign result");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != S_IDLE || done))
    else $error("popped command did not start work");
`endif

endmodule

// ----- hw/rtl/kmeans_assign_accumulate_top.sv -----
// Channel   Handshake               Payload
// -------   ---------------------   -------------------------------------------------
// input     start & !busy           operation, center_slot, coord_x, coord_y
// result    done (one cycle)        cluster_index, best_distance, sum_x, sum_y,
//                                   member_count
// config    psel&penable&pwrite     paddr, pwdata, prdata (pready tied high)
//
// Back end: load/read pass through the accumulate and result states, clear answers
// from idle, and assign scans the N active centers before them; the shared distance
// unit visits one center at a time (memory read, square, compare).
// A 2-word command queue sits between front and back; busy rises when it is full.
// Reset (rst, synchronous) empties the queue, zeroes the accumulators through
// their valid bits and sets num_centers to 2. Centers are undefined until loaded.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module kmeans_assign_accumulate_top import kaa_pkg::*; #(
  parameter int MAX_CENTERS = MAX_CENTERS_DEF,
  parameter int SUM_BITS    = SUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic [SLOT_BITS-1:0]           center_slot,
  input  logic signed [COORD_BITS-1:0]   coord_x,
  input  logic signed [COORD_BITS-1:0]   coord_y,
  // result channel
  output logic                           done,
  output logic [SLOT_BITS-1:0]           cluster_index,
  output logic [DIST_BITS-1:0]           best_distance,
  output logic signed [OUT_SUM_BITS-1:0] sum_x,
  output logic signed [OUT_SUM_BITS-1:0] sum_y,
  output logic [COUNT_BITS-1:0]          member_count,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [NC_BITS-1:0] num_centers;
  logic               reg_sel;
  logic               reg_wr;
  logic               pop;
  logic               cmd_valid;
  cmd_t               cmd;

  // single register at byte address 0; paddr[2] set means off the map
  assign pready  = 1'b1;
  assign reg_sel = !paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? 32'(num_centers) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_centers <= NC_RESET;
    end else if (reg_wr) begin
      num_centers <= pwdata[NC_BITS-1:0];
    end
  end

  // front: decode and queue incoming words
  kaa_front #(
    .MAX_CENTERS (MAX_CENTERS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .center_slot (center_slot),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .busy        (busy),
    .pop         (pop),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  // back: center scan, accumulate, result register
  kaa_back #(
    .MAX_CENTERS (MAX_CENTERS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .pop           (pop),
    .num_centers   (num_centers),
    .done          (done),
    .cluster_index (cluster_index),
    .best_distance (best_distance),
    .sum_x         (sum_x),
    .sum_y         (sum_y),
    .member_count  (member_count)
  );

endmodule
